// ===== rtl/etp_pkg.sv =====
// ----------------------------------------------------------------------------
// etp_pkg
// Shared types and fixed field widths for the exclusive time profiler.
// ----------------------------------------------------------------------------
package etp_pkg;

	localparam int ID_W    = 7;
	localparam int TS_W    = 32;
	localparam int TOTAL_W = 32;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_END   = 2'd1,
		OP_QUERY = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_BACK  = 2'd3
	} status_t;

endpackage

// ===== rtl/exclusive_time_profiler_top.sv =====
// ----------------------------------------------------------------------------
// exclusive_time_profiler_top
// Call-stack based exclusive time accounting over parsed trace events.
// ----------------------------------------------------------------------------
// An accepted event is registered into the stage 1 registers; done and the
// result are driven from the stage 2 registers that follow them.
// Throughput: one event per cycle; busy stays low, start may be held high.
// The top of stack and the entry below it sit in registers, so pushes and
// pops issue back to back; the total table uses one read and one write port.
// Reset: arst_n clears the stack count, last boundary and all table valid bits.
// ----------------------------------------------------------------------------
module exclusive_time_profiler_top
	import etp_pkg::*;
#(
	parameter int NUM_FUNCS   = 128,
	parameter int STACK_DEPTH = 64,
	parameter int TIME_BITS   = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic [ID_W-1:0]    func_id,
	input  logic [TS_W-1:0]    timestamp,
	output logic               done,
	output logic               total_valid,
	output logic [ID_W-1:0]    report_id,
	output logic [TOTAL_W-1:0] total,
	output logic [1:0]         status
);

	localparam int FIDX_W = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
	localparam int SA_W   = $clog2(STACK_DEPTH);
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int TW     = TIME_BITS + 1;

	// state
	logic [CNT_W-1:0]   cnt_q;
	logic [TW-1:0]      last_q;
	logic [ID_W-1:0]    top_q;
	logic [ID_W-1:0]    stk_mem [STACK_DEPTH];
	logic [ID_W-1:0]    stk_rd_q;
	logic               below_fwd_q;
	logic [ID_W-1:0]    below_val_q;
	logic [TOTAL_W-1:0] tbl_mem [NUM_FUNCS];
	logic [NUM_FUNCS-1:0] tbl_vld_q;

	// stage 1
	logic               act_s1;
	logic               wr_s1;
	logic               tv_s1;
	logic [ID_W-1:0]    rid_s1;
	logic [TW-1:0]      amt_s1;
	status_t            st_s1;
	logic [FIDX_W-1:0]  addr_s1;
	logic [TOTAL_W-1:0] mem_rd_s1;
	logic               rvld_s1;
	logic               fwd_s1;
	logic [TOTAL_W-1:0] fwd_data_s1;

	// stage 2
	logic               done_s2;
	logic               tv_s2;
	logic [ID_W-1:0]    rid_s2;
	logic [TOTAL_W-1:0] total_s2;
	status_t            st_s2;

	// stage 0 logic
	logic               acc;
	op_t                op;
	logic [63:0]        ts64;
	logic [TW-1:0]      time_e;
	logic [TW-1:0]      edge_e;
	logic               back_s;
	logic               back_e;
	logic               empty;
	logic               full;
	logic [ID_W-1:0]    sel_id;
	logic [31:0]        sel_ext;
	logic               sel_inr;
	logic [FIDX_W-1:0]  rd_addr;
	logic               charge;
	logic               report;
	logic [ID_W-1:0]    rid;
	logic [TW-1:0]      amt;
	status_t            st;
	logic               push;
	logic               pop;
	logic               push_wr;
	logic [TW-1:0]      last_nx;
	logic [CNT_W-1:0]   cnt_nx;
	logic [CNT_W-1:0]   raddr_full;
	logic [CNT_W-1:0]   waddr_full;
	logic [ID_W-1:0]    below;

	// stage 1 logic
	logic [TOTAL_W-1:0] rd_val;
	logic [63:0]        amt64;
	logic [TOTAL_W:0]   sum33;
	logic               sat;
	logic [TOTAL_W-1:0] sum;

	assign busy   = 1'b0;
	assign acc    = start && !busy;
	assign op     = op_t'(opcode);
	assign ts64   = 64'(timestamp);
	assign time_e = {1'b0, ts64[TIME_BITS-1:0]};
	assign edge_e = time_e + TW'(1);
	assign back_s = time_e < last_q;
	assign back_e = edge_e < last_q;
	assign empty  = (cnt_q == '0);
	assign full   = (cnt_q == CNT_W'(STACK_DEPTH));
	assign below  = below_fwd_q ? below_val_q : stk_rd_q;

	always_comb begin
		sel_id  = top_q;
		charge  = 1'b0;
		report  = 1'b0;
		amt     = '0;
		st      = ST_OK;
		push    = 1'b0;
		pop     = 1'b0;
		last_nx = last_q;
		unique case (op)
			OP_START: begin
				st   = full ? ST_FULL : (back_s ? ST_BACK : ST_OK);
				push = !full;
				if (!back_s) begin
					last_nx = time_e;
					amt     = time_e - last_q;
				end
				if (!empty) begin
					charge = 1'b1;
					report = 1'b1;
				end
			end
			OP_END: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					pop    = 1'b1;
					charge = 1'b1;
					report = 1'b1;
					st     = back_e ? ST_BACK : ST_OK;
					if (!back_e) begin
						last_nx = edge_e;
						amt     = edge_e - last_q;
					end
				end
			end
			OP_QUERY: begin
				sel_id = func_id;
				report = 1'b1;
			end
			OP_NOP: begin
			end
			default: begin
			end
		endcase
	end

	assign sel_ext = 32'(sel_id);
	assign sel_inr = sel_ext < 32'(NUM_FUNCS);
	assign rd_addr = sel_ext[FIDX_W-1:0];
	assign rid     = report ? sel_id : '0;
	assign push_wr = acc && push && !empty;

	always_comb begin
		cnt_nx = cnt_q;
		if (acc && push)
			cnt_nx = cnt_q + CNT_W'(1);
		else if (acc && pop)
			cnt_nx = cnt_q - CNT_W'(1);
	end

	assign raddr_full = cnt_nx - CNT_W'(2);
	assign waddr_full = cnt_q - CNT_W'(1);

	// stack control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			last_q <= '0;
		end else if (acc) begin
			cnt_q  <= cnt_nx;
			last_q <= last_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && push)
			top_q <= func_id;
		else if (acc && pop)
			top_q <= below;
		below_fwd_q <= push_wr;
		below_val_q <= top_q;
	end

	always_ff @(posedge clk) begin
		if (push_wr)
			stk_mem[waddr_full[SA_W-1:0]] <= top_q;
		stk_rd_q <= stk_mem[raddr_full[SA_W-1:0]];
	end

	// total table
	always_ff @(posedge clk) begin
		if (wr_s1)
			tbl_mem[addr_s1] <= sum;
		mem_rd_s1 <= tbl_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_vld_q <= '0;
		end else if (wr_s1) begin
			tbl_vld_q[addr_s1] <= 1'b1;
		end
	end

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
			wr_s1  <= 1'b0;
		end else begin
			act_s1 <= acc;
			wr_s1  <= acc && charge && sel_inr;
		end
	end

	always_ff @(posedge clk) begin
		tv_s1       <= report && sel_inr;
		rid_s1      <= rid;
		amt_s1      <= amt;
		st_s1       <= acc ? st : ST_OK;
		addr_s1     <= rd_addr;
		rvld_s1     <= tbl_vld_q[rd_addr];
		fwd_s1      <= wr_s1 && (addr_s1 == rd_addr);
		fwd_data_s1 <= sum;
	end

	// saturating add
	assign rd_val = fwd_s1 ? fwd_data_s1 : (rvld_s1 ? mem_rd_s1 : '0);
	assign amt64  = 64'(amt_s1);
	assign sum33  = {1'b0, rd_val} + {1'b0, amt64[TOTAL_W-1:0]};
	assign sat    = (|amt64[63:TOTAL_W]) | sum33[TOTAL_W];
	assign sum    = sat ? '1 : sum33[TOTAL_W-1:0];

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= act_s1;
		end
	end

	always_ff @(posedge clk) begin
		tv_s2    <= tv_s1;
		rid_s2   <= rid_s1;
		total_s2 <= tv_s1 ? sum : '0;
		st_s2    <= st_s1;
	end

	assign done        = done_s2;
	assign total_valid = tv_s2;
	assign report_id   = rid_s2;
	assign total       = total_s2;
	assign status      = st_s2;

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result strobe without a matching transfer");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_empty_no_total: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> (!total_valid && total == '0))
		else $error("empty-stack end reported a total");

	a_write_active: assert property (@(posedge clk) disable iff (!arst_n)
		wr_s1 |-> (act_s1 && tv_s1))
		else $error("table write without a reporting item");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && op == OP_START && !full) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("start did not grow the stack");

endmodule
